/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with the standard reset guard and a fixed report
`define FFCA_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ffca assertion failed");

// Same, with a caller-supplied report string
`define FFCA_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

/* hw/rtl/ffca_pkg.sv */
// Package: constants, types and codes of the first-fit allocator
`timescale 1ns / 1ps
package ffca_pkg;

    localparam int ADDR_BITS    = 24;
    localparam int SIZE_BITS    = ADDR_BITS + 1;
    localparam int WIDE_BITS    = SIZE_BITS + 1;
    localparam int CFG_BITS     = 25;
    localparam int CTR_BITS     = 32;
    localparam int HEADER_BYTES = 8;
    localparam int ALIGN_BYTES  = 8;
    localparam int MAX_BLOCKS   = 32;
    localparam int USED_DEPTH   = MAX_BLOCKS;
    localparam int FREE_DEPTH   = MAX_BLOCKS + 1;
    localparam int SLOT_BITS    = $clog2(USED_DEPTH);
    localparam int CNT_BITS     = $clog2(FREE_DEPTH + 1);
    localparam int SPLIT_MIN    = 2 * HEADER_BYTES;
    localparam int HEAP_RESET   = 1048576;
    localparam int HEAP_MAX     = 1 << ADDR_BITS;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_SIZE  = 3'd1,
        STATUS_NO_FIT    = 3'd2,
        STATUS_NOT_ALLOC = 3'd3,
        STATUS_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PASS_A,
        ST_PASS_B,
        ST_PASS_C,
        ST_DONE
    } state_t;

    // one segment held in a cell
    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_BITS-1:0] size;
    } seg_t;

    // control broadcast to a row of cells
    typedef struct packed {
        logic shift;
        logic init;
    } cell_ctl_t;

endpackage

/* hw/rtl/ffca_if.sv */
// Interfaces: request and response channels of the allocator
`timescale 1ns / 1ps
interface ffca_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ffca_pkg::ADDR_BITS-1:0] request_size;
    logic [ffca_pkg::ADDR_BITS-1:0] block_address;

    modport source (output valid, kind, request_size, block_address, input ready);
    modport sink   (input valid, kind, request_size, block_address, output ready);
endinterface

interface ffca_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     status;
    logic [ffca_pkg::ADDR_BITS-1:0] granted_address;
    logic [ffca_pkg::SIZE_BITS-1:0] free_total;
    logic [ffca_pkg::SIZE_BITS-1:0] free_low_mark;
    logic [ffca_pkg::CTR_BITS-1:0]  alloc_total;
    logic [ffca_pkg::CTR_BITS-1:0]  release_total;

    modport source (output valid, status, granted_address, free_total, free_low_mark,
                    alloc_total, release_total, input ready);
    modport sink   (input valid, status, granted_address, free_total, free_low_mark,
                    alloc_total, release_total, output ready);
endinterface

/* hw/rtl/first_fit_coalescing_allocator.sv */
// Top level: first-fit heap allocator with coalescing, built on two rings of cells
// Sequence: allocate runs a free-ring pass, a used-ring pass and a rewrite pass, then
//   the result; free runs the used-ring pass first. Zero, oversized or low-address
//   requests go straight to the result; a miss ends once its pass is done.
// Throughput: one transaction at a time.
// Reset: asynchronous, active low; the ST_INIT state rebuilds the heap (1 MiB) before
//   ready rises, and a cfg_we heap-size write takes the same rebuild.
`timescale 1ns / 1ps
module first_fit_coalescing_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    ffca_req_if.sink                      req,
    ffca_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [ffca_pkg::CFG_BITS-1:0] cfg_wdata
);
    import ffca_pkg::*;

    // ------------------------------------------------------------------
    // Cell rings. Shifted, a ring rotates one place a cycle: cell 0 is the
    // head the sequencer inspects, the last cell takes what the sequencer
    // feeds back. A full rotation (FREE_DEPTH or USED_DEPTH steps) restores order.
    // ------------------------------------------------------------------
    seg_t      fq [FREE_DEPTH];
    seg_t      fd [FREE_DEPTH];
    seg_t      f_init [FREE_DEPTH];
    seg_t      uq [USED_DEPTH];
    seg_t      ud [USED_DEPTH];
    seg_t      f_tail;
    seg_t      u_tail;
    seg_t      e_seg;
    cell_ctl_t f_ctl;
    cell_ctl_t u_ctl;

    genvar gi;
    generate
        for (gi = 0; gi < FREE_DEPTH; gi++)
        begin : g_free
            if (gi == FREE_DEPTH - 1)
            begin : g_tail
                assign fd[gi] = f_tail;
            end
            else
            begin : g_mid
                assign fd[gi] = fq[gi+1];
            end
            // only the lowest cell holds the initial segment
            assign f_init[gi] = (gi == 0) ? e_seg : '0;
            ffca_free_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (f_ctl),
                .init_seg (f_init[gi]),
                .d        (fd[gi]),
                .q        (fq[gi])
            );
        end
        for (gi = 0; gi < USED_DEPTH; gi++)
        begin : g_used
            if (gi == USED_DEPTH - 1)
            begin : g_tail
                assign ud[gi] = u_tail;
            end
            else
            begin : g_mid
                assign ud[gi] = uq[gi+1];
            end
            ffca_used_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (u_ctl),
                .d     (ud[gi]),
                .q     (uq[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  kind_reg, kind_next;
    logic [WIDE_BITS-1:0]  w_reg, w_next;            // rounded request
    logic [ADDR_BITS-1:0]  s_reg, s_next;            // fit start / block start
    logic [SIZE_BITS-1:0]  fsize_reg, fsize_next;    // size of the fitting segment
    logic [SIZE_BITS-1:0]  z_reg, z_next;            // size of block being freed
    logic [SIZE_BITS-1:0]  madd_reg, madd_next;      // z plus upper neighbour size
    logic [ADDR_BITS-1:0]  lo_start_reg, lo_start_next;
    logic                  found_reg, found_next;
    logic                  lo_reg, lo_next;
    logic                  hi_reg, hi_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;
    seg_t                  carry_reg, carry_next;    // bubble carry for the rewrite
    logic [CNT_BITS-1:0]   count_reg, count_next;    // free segments held
    logic [SIZE_BITS-1:0]  bfree_reg, bfree_next;
    logic [SIZE_BITS-1:0]  bmin_reg, bmin_next;
    logic [CTR_BITS-1:0]   allocs_reg, allocs_next;
    logic [CTR_BITS-1:0]   frees_reg, frees_next;
    logic [CFG_BITS-1:0]   heap_reg, heap_next;
    status_t               st_reg, st_next;
    logic [ADDR_BITS-1:0]  gr_reg, gr_next;

    // result register
    logic                  rsp_valid_reg, rsp_valid_next;
    status_t               rsp_st_reg, rsp_st_next;
    logic [ADDR_BITS-1:0]  rsp_gr_reg, rsp_gr_next;
    logic [SIZE_BITS-1:0]  rsp_bf_reg, rsp_bf_next;
    logic [SIZE_BITS-1:0]  rsp_bm_reg, rsp_bm_next;
    logic [CTR_BITS-1:0]   rsp_al_reg, rsp_al_next;
    logic [CTR_BITS-1:0]   rsp_fr_reg, rsp_fr_next;

    // derived values
    logic [WIDE_BITS-1:0]  hdr_sum;
    logic [WIDE_BITS-1:0]  w_round;
    logic [CFG_BITS-1:0]   e_raw;
    logic [CFG_BITS-1:0]   e_val;
    logic [SIZE_BITS-1:0]  rem;
    logic                  split;
    logic [SIZE_BITS-1:0]  sz;
    logic [ADDR_BITS-1:0]  new_start;
    logic [SIZE_BITS-1:0]  se;
    logic [SIZE_BITS-1:0]  bf_alloc;
    logic                  last_free;
    logic                  last_used;

    always_comb
    begin
        hdr_sum = WIDE_BITS'(req.request_size) + WIDE_BITS'(HEADER_BYTES);
        w_round = hdr_sum + WIDE_BITS'(ALIGN_BYTES - 1);
        w_round = w_round - (w_round % WIDE_BITS'(ALIGN_BYTES));

        // initial free segment: heap less the header, rounded down
        e_raw = heap_reg - CFG_BITS'(HEADER_BYTES);
        e_val = (heap_reg >= CFG_BITS'(HEADER_BYTES))
              ? e_raw - (e_raw % CFG_BITS'(ALIGN_BYTES)) : '0;
        e_seg = '{valid: (e_val != '0), start: '0, size: SIZE_BITS'(e_val)};

        rem       = fsize_reg - SIZE_BITS'(w_reg);
        split     = rem > SIZE_BITS'(SPLIT_MIN);
        sz        = split ? SIZE_BITS'(w_reg) : fsize_reg;
        new_start = s_reg + ADDR_BITS'(w_reg);
        se        = SIZE_BITS'(s_reg) + z_reg;
        bf_alloc  = bfree_reg - sz;
        last_free = cnt_reg == CNT_BITS'(FREE_DEPTH - 1);
        last_used = cnt_reg == CNT_BITS'(USED_DEPTH - 1);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and ring control
    // ------------------------------------------------------------------
    always_comb
    begin
        seg_t h;
        logic h_first;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        w_next         = w_reg;
        s_next         = s_reg;
        fsize_next     = fsize_reg;
        z_next         = z_reg;
        madd_next      = madd_reg;
        lo_start_next  = lo_start_reg;
        found_next     = found_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        slot_next      = slot_reg;
        carry_next     = carry_reg;
        count_next     = count_reg;
        bfree_next     = bfree_reg;
        bmin_next      = bmin_reg;
        allocs_next    = allocs_reg;
        frees_next     = frees_reg;
        heap_next      = heap_reg;
        st_next        = st_reg;
        gr_next        = gr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_st_next    = rsp_st_reg;
        rsp_gr_next    = rsp_gr_reg;
        rsp_bf_next    = rsp_bf_reg;
        rsp_bm_next    = rsp_bm_reg;
        rsp_al_next    = rsp_al_reg;
        rsp_fr_next    = rsp_fr_reg;
        f_ctl          = '0;
        u_ctl          = '0;
        f_tail         = fq[0];
        u_tail         = uq[0];
        h              = fq[0];
        h_first        = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                f_ctl.init  = 1'b1;
                u_ctl.init  = 1'b1;
                carry_next  = '0;
                count_next  = (e_val != '0) ? CNT_BITS'(1) : '0;
                bfree_next  = SIZE_BITS'(e_val);
                bmin_next   = SIZE_BITS'(e_val);
                allocs_next = '0;
                frees_next  = '0;
                state_next  = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    lo_next    = 1'b0;
                    hi_next    = 1'b0;
                    gr_next    = '0;
                    state_next = ST_PASS_A;
                    if (req.kind == KIND_ALLOC)
                    begin
                        w_next = w_round;
                        if (req.request_size == '0 ||
                            w_round > WIDE_BITS'(bfree_reg))
                        begin
                            st_next    = STATUS_BAD_SIZE;
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        s_next = req.block_address - ADDR_BITS'(HEADER_BYTES);
                        if (req.block_address < ADDR_BITS'(HEADER_BYTES))
                        begin
                            st_next    = STATUS_NOT_ALLOC;
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_PASS_A:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (kind_reg == KIND_ALLOC)
                begin
                    // first-fit search: keep the lowest-addressed fitting segment,
                    // as emptied cells may leave gaps in the ring
                    f_ctl.shift = 1'b1;
                    if (fq[0].valid && (!found_reg || fq[0].start < s_reg) &&
                        WIDE_BITS'(fq[0].size) >= w_reg)
                    begin
                        found_next = 1'b1;
                        s_next     = fq[0].start;
                        fsize_next = fq[0].size;
                    end
                    if (last_free)
                    begin
                        cnt_next   = '0;
                        state_next = found_next ? ST_PASS_B : ST_DONE;
                        st_next    = STATUS_NO_FIT;
                        found_next = 1'b0;
                    end
                end
                else
                begin
                    // look the block up among the used slots
                    u_ctl.shift = 1'b1;
                    if (uq[0].valid && !found_reg && uq[0].start == s_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = cnt_reg[SLOT_BITS-1:0];
                        z_next     = uq[0].size;
                        madd_next  = uq[0].size;
                    end
                    if (last_used)
                    begin
                        cnt_next   = '0;
                        state_next = found_next ? ST_PASS_B : ST_DONE;
                        st_next    = STATUS_NOT_ALLOC;
                    end
                end
            end

            ST_PASS_B:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (kind_reg == KIND_ALLOC)
                begin
                    // any empty used slot will do
                    u_ctl.shift = 1'b1;
                    if (!uq[0].valid && !found_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = cnt_reg[SLOT_BITS-1:0];
                    end
                    if (last_used)
                    begin
                        cnt_next   = '0;
                        carry_next = '0;
                        state_next = found_next ? ST_PASS_C : ST_DONE;
                        st_next    = STATUS_FULL;
                    end
                end
                else
                begin
                    // find the neighbours that touch the block
                    f_ctl.shift = 1'b1;
                    if (fq[0].valid)
                    begin
                        if (SIZE_BITS'(fq[0].start) + fq[0].size == SIZE_BITS'(s_reg))
                        begin
                            lo_next       = 1'b1;
                            lo_start_next = fq[0].start;
                        end
                        if (SIZE_BITS'(fq[0].start) == se)
                        begin
                            hi_next   = 1'b1;
                            madd_next = z_reg + fq[0].size;
                        end
                    end
                    if (last_free)
                    begin
                        cnt_next   = '0;
                        carry_next = '0;
                        state_next = ST_PASS_C;
                        if (!lo_next && !hi_next)
                        begin
                            // standalone segment enters through the carry
                            carry_next = '{valid: 1'b1, start: s_reg, size: z_reg};
                            if (count_reg >= CNT_BITS'(FREE_DEPTH))
                            begin
                                st_next    = STATUS_FULL;
                                state_next = ST_DONE;
                            end
                        end
                    end
                end
            end

            ST_PASS_C:
            begin
                // rewrite pass: edit the head, then one bubble step merges the
                // carry into the stream; an emptied cell may stay as a gap
                cnt_next    = cnt_reg + CNT_BITS'(1);
                f_ctl.shift = 1'b1;
                u_ctl.shift = cnt_reg < CNT_BITS'(USED_DEPTH);
                if (kind_reg == KIND_ALLOC)
                begin
                    if (fq[0].valid && fq[0].start == s_reg)
                    begin
                        h = split ? '{valid: 1'b1, start: new_start, size: rem}
                                  : '{valid: 1'b0, start: fq[0].start, size: fq[0].size};
                    end
                    if (cnt_reg == CNT_BITS'(slot_reg))
                    begin
                        u_tail = '{valid: 1'b1, start: s_reg, size: sz};
                    end
                end
                else
                begin
                    if (lo_reg && fq[0].valid && fq[0].start == lo_start_reg)
                    begin
                        h.size = fq[0].size + madd_reg;
                    end
                    if (hi_reg && fq[0].valid && SIZE_BITS'(fq[0].start) == se)
                    begin
                        h = lo_reg ? '{valid: 1'b0, start: fq[0].start, size: fq[0].size}
                                   : '{valid: 1'b1, start: s_reg, size: fq[0].size + z_reg};
                    end
                    if (cnt_reg == CNT_BITS'(slot_reg))
                    begin
                        u_tail.valid = 1'b0;
                    end
                end
                h_first = h.valid && (!carry_reg.valid || h.start < carry_reg.start);
                f_tail     = h_first ? h : carry_reg;
                carry_next = h_first ? carry_reg : h;

                if (last_free)
                begin
                    st_next    = STATUS_OK;
                    state_next = ST_DONE;
                    if (kind_reg == KIND_ALLOC)
                    begin
                        count_next  = split ? count_reg : count_reg - CNT_BITS'(1);
                        bfree_next  = bf_alloc;
                        bmin_next   = (bf_alloc < bmin_reg) ? bf_alloc : bmin_reg;
                        allocs_next = allocs_reg + CTR_BITS'(1);
                        gr_next     = s_reg + ADDR_BITS'(HEADER_BYTES);
                    end
                    else
                    begin
                        if (lo_reg && hi_reg)
                        begin
                            count_next = count_reg - CNT_BITS'(1);
                        end
                        else if (!lo_reg && !hi_reg)
                        begin
                            count_next = count_reg + CNT_BITS'(1);
                        end
                        bfree_next = bfree_reg + z_reg;
                        frees_next = frees_reg + CTR_BITS'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_st_next    = st_reg;
                    rsp_gr_next    = (st_reg == STATUS_OK) ? gr_reg : '0;
                    rsp_bf_next    = bfree_reg;
                    rsp_bm_next    = bmin_reg;
                    rsp_al_next    = allocs_reg;
                    rsp_fr_next    = frees_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // heap size write: saturate and rebuild
        if (cfg_we)
        begin
            heap_next  = (cfg_wdata > CFG_BITS'(HEAP_MAX)) ? CFG_BITS'(HEAP_MAX) : cfg_wdata;
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            kind_reg      <= KIND_ALLOC;
            found_reg     <= 1'b0;
            lo_reg        <= 1'b0;
            hi_reg        <= 1'b0;
            carry_reg     <= '0;
            count_reg     <= '0;
            bfree_reg     <= '0;
            bmin_reg      <= '0;
            allocs_reg    <= '0;
            frees_reg     <= '0;
            heap_reg      <= CFG_BITS'(HEAP_RESET);
            st_reg        <= STATUS_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            found_reg     <= found_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            carry_reg     <= carry_next;
            count_reg     <= count_next;
            bfree_reg     <= bfree_next;
            bmin_reg      <= bmin_next;
            allocs_reg    <= allocs_next;
            frees_reg     <= frees_next;
            heap_reg      <= heap_next;
            st_reg        <= st_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        s_reg        <= s_next;
        fsize_reg    <= fsize_next;
        z_reg        <= z_next;
        madd_reg     <= madd_next;
        lo_start_reg <= lo_start_next;
        slot_reg     <= slot_next;
        gr_reg       <= gr_next;
        rsp_st_reg   <= rsp_st_next;
        rsp_gr_reg   <= rsp_gr_next;
        rsp_bf_reg   <= rsp_bf_next;
        rsp_bm_reg   <= rsp_bm_next;
        rsp_al_reg   <= rsp_al_next;
        rsp_fr_reg   <= rsp_fr_next;
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_st_reg;
    assign rsp.granted_address = rsp_gr_reg;
    assign rsp.free_total      = rsp_bf_reg;
    assign rsp.free_low_mark   = rsp_bm_reg;
    assign rsp.alloc_total     = rsp_al_reg;
    assign rsp.release_total   = rsp_fr_reg;

endmodule

/* hw/rtl/ffca_free_cell.sv */
// Free-segment cell: one entry of the address-ordered free ring
`timescale 1ns / 1ps
module ffca_free_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ffca_pkg::cell_ctl_t ctl,
    input  ffca_pkg::seg_t      init_seg,
    input  ffca_pkg::seg_t      d,
    output ffca_pkg::seg_t      q
);
    import ffca_pkg::*;

    logic                 valid_reg;
    logic [ADDR_BITS-1:0] start_reg;
    logic [SIZE_BITS-1:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.init)
        begin
            valid_reg <= init_seg.valid;
        end
        else if (ctl.shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            start_reg <= init_seg.start;
            size_reg  <= init_seg.size;
        end
        else if (ctl.shift)
        begin
            start_reg <= d.start;
            size_reg  <= d.size;
        end
    end

    assign q = '{valid: valid_reg, start: start_reg, size: size_reg};

endmodule

/* hw/rtl/ffca_used_cell.sv */
// Used-block cell: one slot of the allocated-block ring
`timescale 1ns / 1ps
module ffca_used_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ffca_pkg::cell_ctl_t ctl,
    input  ffca_pkg::seg_t      d,
    output ffca_pkg::seg_t      q
);
    import ffca_pkg::*;

    logic                 valid_reg;
    logic [ADDR_BITS-1:0] start_reg;
    logic [SIZE_BITS-1:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.init)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= d.valid;
        end
    end

    // payload only meaningful while valid
    always_ff @(posedge clk)
    begin
        if (ctl.shift && !ctl.init)
        begin
            start_reg <= d.start;
            size_reg  <= d.size;
        end
    end

    assign q = '{valid: valid_reg, start: start_reg, size: size_reg};

endmodule

/* hw/rtl/ffca_checker.sv */
// Checker: port-level properties of the allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffca_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [2:0]                     rsp_status,
    input logic [ffca_pkg::ADDR_BITS-1:0] rsp_granted,
    input logic [ffca_pkg::SIZE_BITS-1:0] rsp_free_total,
    input logic [ffca_pkg::SIZE_BITS-1:0] rsp_free_low
);
    import ffca_pkg::*;

    `FFCA_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid)
    `FFCA_ASSERT_MSG(a_one_at_a_time, clk, rst_n, req_valid && req_ready |=> !req_ready, "request taken while busy")
    `FFCA_ASSERT_MSG(a_fail_no_addr, clk, rst_n, rsp_valid && rsp_status != STATUS_OK |-> rsp_granted == '0, "address on failed transaction")
    `FFCA_ASSERT(a_low_mark, clk, rst_n, rsp_valid |-> rsp_free_low <= rsp_free_total)

endmodule

bind first_fit_coalescing_allocator ffca_checker u_ffca_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_granted    (rsp.granted_address),
    .rsp_free_total (rsp.free_total),
    .rsp_free_low   (rsp.free_low_mark)
);
